// ===== rtl/coil_winder_stepper_sequencer_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the coil winder checker.
// ----------------------------------------------------------------------------
`ifndef COIL_WINDER_STEPPER_SEQUENCER_CORE_ASSERT_SVH
`define COIL_WINDER_STEPPER_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CWSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cwss assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CWSS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cwss assertion failed");

`endif

// ===== rtl/cwss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coil winder sequencer package
// Types, codes and constant tables shared by the controller and datapath.
// ----------------------------------------------------------------------------
package cwss_pkg;

    // Elapsed tick counters saturate at all ones.
    localparam int ELAPSED_W = 17;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    // Traverse interval division: 20-bit dividend, 8-bit divisor.
    localparam int QUO_W = 20;
    localparam int DVS_W = 8;
    localparam int CNT_W = 5;
    localparam logic [CNT_W-1:0] DIV_LAST_CNT = CNT_W'(QUO_W - 1);

    // Request codes.
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_STEPS_PER_TURN  = 2'd0;
    localparam logic [1:0] CFG_TURNS_PER_LAYER = 2'd1;
    localparam logic [1:0] CFG_LAYER_COUNT     = 2'd2;
    localparam logic [1:0] CFG_WIRE_THICKNESS  = 2'd3;

    // Coil patterns: two-phase winding, one-phase traverse both ways.
    localparam logic [3:0] WIND_TAB      [4] = '{4'h3, 4'h6, 4'hC, 4'h9};
    localparam logic [3:0] TRAV_FWD_TAB  [4] = '{4'h1, 4'h2, 4'h4, 4'h8};
    localparam logic [3:0] TRAV_BACK_TAB [4] = '{4'h8, 4'h4, 4'h2, 4'h1};

    // Winding interval 100 / speed, with speed zero read as one.
    localparam logic [6:0] WIND_IV_TAB [32] = '{
        7'd100, 7'd100, 7'd50, 7'd33, 7'd25, 7'd20, 7'd16, 7'd14,
        7'd12,  7'd11,  7'd10, 7'd9,  7'd8,  7'd7,  7'd7,  7'd6,
        7'd6,   7'd5,   7'd5,  7'd5,  7'd5,  7'd4,  7'd4,  7'd4,
        7'd4,   7'd4,   7'd3,  7'd3,  7'd3,  7'd3,  7'd3,  7'd3
    };

    // Traverse divisor thickness * 100 / 38, with zero forced to one.
    localparam logic [7:0] STEP_NO_TAB [64] = '{
        8'd1,   8'd2,   8'd5,   8'd7,   8'd10,  8'd13,  8'd15,  8'd18,
        8'd21,  8'd23,  8'd26,  8'd28,  8'd31,  8'd34,  8'd36,  8'd39,
        8'd42,  8'd44,  8'd47,  8'd50,  8'd52,  8'd55,  8'd57,  8'd60,
        8'd63,  8'd65,  8'd68,  8'd71,  8'd73,  8'd76,  8'd78,  8'd81,
        8'd84,  8'd86,  8'd89,  8'd92,  8'd94,  8'd97,  8'd100, 8'd102,
        8'd105, 8'd107, 8'd110, 8'd113, 8'd115, 8'd118, 8'd121, 8'd123,
        8'd126, 8'd128, 8'd131, 8'd134, 8'd136, 8'd139, 8'd142, 8'd144,
        8'd147, 8'd150, 8'd152, 8'd155, 8'd157, 8'd160, 8'd163, 8'd165
    };

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_APPLY
    } cwss_state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic capture;
        logic prep;
        logic div_step;
        logic apply;
    } cwss_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic is_start;
        logic div_last;
    } cwss_sts_t;

endpackage

// ===== rtl/cwss_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coil winder sequencer controller
// Sequences capture, interval division and state update, and owns both
// handshakes.
// ----------------------------------------------------------------------------
module cwss_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  cwss_pkg::cwss_sts_t sts,
    output cwss_pkg::cwss_cmd_t cmd
);
    import cwss_pkg::*;

    cwss_state_t state_reg;
    cwss_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    // State and output-valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (sts.is_start)
                begin
                    state_next = ST_APPLY;
                end
                else
                begin
                    cmd.prep   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                // The result register must be free before state moves on.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.apply  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A result stays valid until its transfer.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.apply)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/cwss_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coil winder sequencer datapath
// Configuration, run counters, motor phases, and the traverse interval
// divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cwss_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  cwss_pkg::cwss_cmd_t cmd,
    output cwss_pkg::cwss_sts_t sts,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    input  logic                req_type,
    input  logic [4:0]          speed_setting,
    output logic [3:0]          coil_a,
    output logic [3:0]          coil_b,
    output logic [7:0]          steps_left,
    output logic [6:0]          turns_left,
    output logic [4:0]          layers_left,
    output logic                traverse_reverse,
    output logic                done_res,
    output logic                busy_res
);
    import cwss_pkg::*;

    // Configuration registers.
    logic [7:0] spt_reg;
    logic [6:0] tpl_reg;
    logic [4:0] lc_reg;
    logic [5:0] wire_reg;

    // Captured input item.
    logic       req_reg;
    logic [4:0] speed_reg;

    // Divider.
    logic [QUO_W-1:0] quo_reg;
    logic [QUO_W-1:0] quo_next;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] rem_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [6:0]       wiv_reg;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic [6:0]       wiv_lookup;
    logic [13:0]      prod;
    logic [QUO_W-1:0] dividend;

    // Run state.
    logic                 run_reg,  run_next;
    logic [7:0]           sc_reg,   sc_next;
    logic [6:0]           tc_reg,   tc_next;
    logic [4:0]           ll_reg,   ll_next;
    logic                 rd_reg,   rd_next;
    logic [1:0]           wph_reg,  wph_next;
    logic [1:0]           tph_reg,  tph_next;
    logic [ELAPSED_W-1:0] we_reg,   we_next;
    logic [ELAPSED_W-1:0] te_reg,   te_next;
    logic [3:0]           wpat_reg, wpat_next;
    logic [3:0]           tpat_reg, tpat_next;
    logic                 done_reg, done_next;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spt_reg  <= 8'd60;
            tpl_reg  <= 7'd4;
            lc_reg   <= 5'd1;
            wire_reg <= 6'd2;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STEPS_PER_TURN:  spt_reg  <= cfg_data;
                CFG_TURNS_PER_LAYER: tpl_reg  <= cfg_data[6:0];
                CFG_LAYER_COUNT:     lc_reg   <= cfg_data[4:0];
                CFG_WIRE_THICKNESS:  wire_reg <= cfg_data[5:0];
                default:             spt_reg  <= spt_reg;
            endcase
        end
    end

    // Input capture.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg   <= req_type;
            speed_reg <= speed_setting;
        end
    end

    // Dividend 60 * turns * winding interval; times 60 as two shifts.
    assign wiv_lookup = WIND_IV_TAB[speed_reg];
    assign prod       = 14'(tpl_reg) * 14'(wiv_lookup);
    assign dividend   = {prod, 6'b0} - {4'b0, prod, 2'b0};

    // One restoring division step.
    assign trial = {rem_reg, quo_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        if (!diff[DVS_W])
        begin
            rem_next = diff[DVS_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[DVS_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= STEP_NO_TAB[wire_reg];
            cnt_reg <= DIV_LAST_CNT;
            wiv_reg <= wiv_lookup;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign sts.is_start = (req_reg == REQ_START);
    assign sts.div_last = (cnt_reg == '0);

    // Item update: start loads the run, tick advances both motors while a run is in progress.
    always_comb
    begin
        run_next  = run_reg;
        sc_next   = sc_reg;
        tc_next   = tc_reg;
        ll_next   = ll_reg;
        rd_next   = rd_reg;
        wph_next  = wph_reg;
        tph_next  = tph_reg;
        we_next   = we_reg;
        te_next   = te_reg;
        wpat_next = wpat_reg;
        tpat_next = tpat_reg;
        done_next = 1'b0;
        if (req_reg == REQ_START)
        begin
            run_next = 1'b1;
            sc_next  = spt_reg;
            tc_next  = tpl_reg;
            ll_next  = lc_reg;
            rd_next  = 1'b1;
            we_next  = ELAPSED_MAX;
            te_next  = ELAPSED_MAX;
        end
        else if (run_reg)
        begin
            // Turn and layer bookkeeping.
            if (sc_next == '0)
            begin
                sc_next = spt_reg;
                tc_next = (tc_next != '0) ? tc_next - 1'b1 : tc_next;
            end
            if (tc_next == '0)
            begin
                ll_next = (ll_next != '0) ? ll_next - 1'b1 : ll_next;
                tc_next = tpl_reg;
                rd_next = ~rd_next;
            end

            // Winding motor.
            if (ll_next != '0)
            begin
                if (we_next != ELAPSED_MAX)
                begin
                    we_next = we_next + 1'b1;
                end
                if (we_next >= {{(ELAPSED_W-7){1'b0}}, wiv_reg})
                begin
                    we_next   = '0;
                    sc_next   = (sc_next != '0) ? sc_next - 1'b1 : sc_next;
                    wph_next  = wph_next + 1'b1;
                    wpat_next = WIND_TAB[wph_next];
                end
            end
            else
            begin
                done_next = 1'b1;
            end

            // Traverse motor.
            if (te_next != ELAPSED_MAX)
            begin
                te_next = te_next + 1'b1;
            end
            if ({{(QUO_W-ELAPSED_W){1'b0}}, te_next} >= quo_reg)
            begin
                te_next   = '0;
                tph_next  = tph_next + 1'b1;
                tpat_next = rd_next ? TRAV_BACK_TAB[tph_next] : TRAV_FWD_TAB[tph_next];
            end

            // End of run switches both motors off.
            if (done_next)
            begin
                run_next  = 1'b0;
                wpat_next = '0;
                tpat_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            sc_reg   <= 8'd60;
            tc_reg   <= '0;
            ll_reg   <= '0;
            rd_reg   <= 1'b1;
            wph_reg  <= 2'd3;
            tph_reg  <= 2'd3;
            we_reg   <= ELAPSED_MAX;
            te_reg   <= ELAPSED_MAX;
            wpat_reg <= '0;
            tpat_reg <= '0;
            done_reg <= 1'b0;
        end
        else if (cmd.apply)
        begin
            run_reg  <= run_next;
            sc_reg   <= sc_next;
            tc_reg   <= tc_next;
            ll_reg   <= ll_next;
            rd_reg   <= rd_next;
            wph_reg  <= wph_next;
            tph_reg  <= tph_next;
            we_reg   <= we_next;
            te_reg   <= te_next;
            wpat_reg <= wpat_next;
            tpat_reg <= tpat_next;
            done_reg <= done_next;
        end
    end

    // State holds while the result is pending, so it drives the result.
    assign coil_a           = wpat_reg;
    assign coil_b           = tpat_reg;
    assign steps_left       = sc_reg;
    assign turns_left       = tc_reg;
    assign layers_left      = ll_reg;
    assign traverse_reverse = rd_reg;
    assign done_res         = done_reg;
    assign busy_res         = run_reg;

endmodule

// ===== rtl/coil_winder_stepper_sequencer_core.sv =====
`timescale 1ns / 1ps
// A start result is registered by the state update after capture; a tick result waits for
// the 20-step traverse interval divider in the datapath first. Items are taken one at a time:
// the next item is accepted only after the previous one has updated the state.
// A new item is taken while the previous result still waits for its transfer.
// Reset (rst_n, asynchronous, active low) restores default registers and idles the run.
// ----------------------------------------------------------------------------
// Coil winder stepper sequencer
// Winding and traverse stepper sequencing for a coil winder, one result per item.
// ----------------------------------------------------------------------------
module coil_winder_stepper_sequencer_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       req_type,
    input  logic [4:0] speed_setting,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] coil_a,
    output logic [3:0] coil_b,
    output logic [7:0] steps_left,
    output logic [6:0] turns_left,
    output logic [4:0] layers_left,
    output logic       traverse_reverse,
    output logic       done_res,
    output logic       busy_res
);
    import cwss_pkg::*;

    cwss_cmd_t cmd;
    cwss_sts_t sts;

    // Sequencing and handshakes.
    cwss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Counters, phases and divider.
    cwss_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .req_type         (req_type),
        .speed_setting    (speed_setting),
        .coil_a           (coil_a),
        .coil_b           (coil_b),
        .steps_left       (steps_left),
        .turns_left       (turns_left),
        .layers_left      (layers_left),
        .traverse_reverse (traverse_reverse),
        .done_res         (done_res),
        .busy_res         (busy_res)
    );

endmodule

// ===== rtl/cwss_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coil winder sequencer checker
// Port-level properties of the sequencer, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "coil_winder_stepper_sequencer_core_assert.svh"

module cwss_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] coil_a,
    input logic [3:0] coil_b,
    input logic       done_res,
    input logic       busy_res
);

    // A pending result is not dropped.
    `CWSS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    // One item at a time: an input transfer closes the input side.
    `CWSS_ASSERT_NXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)

    // A finished run is no longer busy.
    `CWSS_ASSERT_IMP(a_done_idle, clk, rst_n, out_valid && done_res, !busy_res)

    // With no run in progress both motors are off.
    `CWSS_ASSERT_IMP(a_idle_coils_off, clk, rst_n, out_valid && !busy_res,
        coil_a == 4'h0 && coil_b == 4'h0)

endmodule

bind coil_winder_stepper_sequencer_core cwss_checker u_cwss_checker (.*);
